### src/gha_pkg.sv
// Shared types and constants for the generational handle allocator.
// No dependencies; every other file in src imports this package.
`default_nettype none

package gha_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = 16;
	localparam int SIZE_W   = $clog2(CAPACITY + 1);
	localparam int TOP_W    = $clog2(CAPACITY + 1);

	localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
	localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(CAPACITY);
	localparam logic [TOP_W-1:0]  TOP_FULL = TOP_W'(CAPACITY);
	localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(CAPACITY - 1);

	typedef enum logic [2:0] {
		OP_ALLOC    = 3'd0,
		OP_RELEASE  = 3'd1,
		OP_QUERY    = 3'd2,
		OP_VALIDATE = 3'd3,
		OP_CLEAR    = 3'd4
	} gha_op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_RANGE     = 2'd2,
		ST_FULL      = 2'd3
	} gha_status_t;

	typedef struct packed {
		logic [2:0]       operation;
		logic [IDX_W-1:0] entry_index;
		logic [CNT_W-1:0] entry_counter;
	} gha_cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] out_index;
		logic [CNT_W-1:0] out_counter;
		logic             handle_valid;
		logic [1:0]       status;
	} gha_rsp_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [CNT_W-1:0] cnt;
	} gha_handle_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [CNT_W-1:0] data;
	} gha_gen_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		gha_handle_t      data;
	} gha_stk_wr_t;

	typedef struct packed {
		logic             active;
		logic [IDX_W-1:0] addr;
	} gha_sweep_t;

endpackage

`default_nettype wire

### src/gha_gen_ram.sv
// Generation counter memory: one write port, one registered read port.
// Depends on gha_pkg.
`default_nettype none

module gha_gen_ram import gha_pkg::*; (
	input  wire logic             clk,
	input  wire gha_gen_wr_t      wr,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output logic      [CNT_W-1:0] rd_data
);

	logic [CNT_W-1:0] mem [CAPACITY];
	logic [CNT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### src/gha_stack_ram.sv
// Free-handle stack memory: one write port, one registered read port.
// Depends on gha_pkg.
`default_nettype none

module gha_stack_ram import gha_pkg::*; (
	input  wire logic             clk,
	input  wire gha_stk_wr_t      wr,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output gha_handle_t           rd_data
);

	gha_handle_t mem [CAPACITY];
	gha_handle_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### src/gha_sweep.sv
// Zeroing sequencer for the generation memory: walks from a start entry to
// the last one, one entry per cycle while hold is low. Depends on gha_pkg.
`default_nettype none

module gha_sweep import gha_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              clear,
	input  wire logic              shrink,
	input  wire logic [SIZE_W-1:0] new_size,
	input  wire logic              hold,
	output gha_sweep_t             sweep
);

	logic             active_q;
	logic [IDX_W-1:0] ptr_q;
	logic             lower_start;

	// A shrink only matters if it reaches below what is still to be zeroed.
	assign lower_start = (new_size < SIZE_CAP) &&
		(!active_q || (new_size[IDX_W-1:0] < ptr_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			ptr_q    <= '0;
		end else begin
			priority if (clear) begin
				active_q <= 1'b1;
				ptr_q    <= '0;
			end else if (shrink && lower_start) begin
				active_q <= 1'b1;
				ptr_q    <= new_size[IDX_W-1:0];
			end else if (active_q && !hold) begin
				if (ptr_q == IDX_LAST) begin
					active_q <= 1'b0;
				end
				ptr_q <= ptr_q + IDX_W'(1);
			end
		end
	end

	assign sweep.active = active_q;
	assign sweep.addr   = ptr_q;

endmodule

`default_nettype wire

### src/generational_handle_allocator.sv
// Top level of the generational handle allocator: command decode, stack and
// fresh-index bookkeeping. Depends on gha_pkg, gha_gen_ram, gha_stack_ram, gha_sweep.
//
//  channel   signals                        direction  transfer
//  command   start, busy, cmd               in         start && !busy
//  result    done, rsp                      out        done, one cycle, no backpressure
//  config    cfg_valid, cfg_ready, cfg_data in         cfg_valid && cfg_ready
//
// For every command, memories are read at the accepting edge, the next cycle
// computes and writes back, and the result shows in the cycle after that.
// After reset and after a clear, the generation memory is zeroed one entry a
// cycle, unless a command write takes the port, while busy is high; a size
// write below capacity zeroes the entries from the new size upward the same way.
// The result is strobed for one cycle and cannot be stalled.
`default_nettype none

module generational_handle_allocator import gha_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire gha_cmd_t          cmd,
	output logic                   done,
	output gha_rsp_t               rsp,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [SIZE_W-1:0] cfg_data
);

	logic              accept;
	logic              cfg_wr;
	logic              s1_valid_q;
	gha_cmd_t          cmd_s1;
	logic [SIZE_W-1:0] active_size_q;
	logic [TOP_W-1:0]  free_top_q;
	logic [SIZE_W-1:0] next_fresh_q;
	logic              done_q;
	gha_rsp_t          rsp_q;

	logic [CNT_W-1:0]  gen_rdata;
	gha_handle_t       stk_rdata;
	gha_gen_wr_t       gen_wr;
	gha_gen_wr_t       op_gen_wr;
	gha_stk_wr_t       stk_wr;
	gha_sweep_t        sweep;

	logic [SIZE_W-1:0] eff_size;
	logic [SIZE_W-1:0] cfg_eff;
	logic              in_range;
	logic [CNT_W-1:0]  stored;
	logic [CNT_W-1:0]  next_cnt;
	logic              do_clear;
	logic              push;
	logic              pop;
	logic              fresh;
	gha_rsp_t          rsp_d;

	assign accept    = start && !busy;
	assign busy      = s1_valid_q || sweep.active;
	// Hold off a size write while a command is being accepted or is in stage 1.
	assign cfg_ready = !s1_valid_q && !accept;
	assign cfg_wr    = cfg_valid && cfg_ready;

	assign eff_size = (active_size_q > SIZE_CAP) ? SIZE_CAP : active_size_q;
	assign cfg_eff  = (cfg_data > SIZE_CAP) ? SIZE_CAP : cfg_data;
	assign in_range = {1'b0, cmd_s1.entry_index} < eff_size;
	assign stored   = in_range ? gen_rdata : '0;
	assign next_cnt = (stored == CNT_MAX) ? CNT_ONE : stored + CNT_ONE;

	// Decode the command held in stage 1 against the words read from memory.
	always_comb begin
		rsp_d      = '0;
		op_gen_wr  = '0;
		stk_wr     = '0;
		do_clear   = 1'b0;
		push       = 1'b0;
		pop        = 1'b0;
		fresh      = 1'b0;
		stk_wr.addr = free_top_q[IDX_W-1:0];
		if (s1_valid_q) begin
			unique case (cmd_s1.operation)
				OP_ALLOC: begin
					if (free_top_q != '0) begin
						pop               = 1'b1;
						rsp_d.out_index   = stk_rdata.idx;
						rsp_d.out_counter = stk_rdata.cnt;
					end else if (next_fresh_q < eff_size) begin
						fresh             = 1'b1;
						op_gen_wr.en      = 1'b1;
						op_gen_wr.addr    = next_fresh_q[IDX_W-1:0];
						op_gen_wr.data    = CNT_ONE;
						rsp_d.out_index   = next_fresh_q[IDX_W-1:0];
						rsp_d.out_counter = CNT_ONE;
					end else begin
						rsp_d.status = ST_EXHAUSTED;
					end
				end
				OP_RELEASE: begin
					rsp_d.out_index = cmd_s1.entry_index;
					if (!in_range) begin
						rsp_d.status = ST_RANGE;
					end else if (free_top_q == TOP_FULL) begin
						rsp_d.status      = ST_FULL;
						rsp_d.out_counter = stored;
					end else begin
						push              = 1'b1;
						op_gen_wr.en      = 1'b1;
						op_gen_wr.addr    = cmd_s1.entry_index;
						op_gen_wr.data    = next_cnt;
						stk_wr.en         = 1'b1;
						stk_wr.data.idx   = cmd_s1.entry_index;
						stk_wr.data.cnt   = next_cnt;
						rsp_d.out_counter = next_cnt;
					end
				end
				OP_QUERY: begin
					rsp_d.out_index   = cmd_s1.entry_index;
					rsp_d.out_counter = stored;
					rsp_d.status      = in_range ? ST_OK : ST_RANGE;
				end
				OP_VALIDATE: begin
					rsp_d.out_index    = cmd_s1.entry_index;
					rsp_d.out_counter  = stored;
					rsp_d.status       = in_range ? ST_OK : ST_RANGE;
					rsp_d.handle_valid = in_range && (cmd_s1.entry_counter == stored) &&
						(cmd_s1.entry_counter != '0);
				end
				OP_CLEAR: begin
					do_clear = 1'b1;
				end
				default: begin
					rsp_d = '0;
				end
			endcase
		end
	end

	// Command writes win the port; the sweep holds its entry meanwhile.
	always_comb begin
		if (op_gen_wr.en) begin
			gen_wr = op_gen_wr;
		end else begin
			gen_wr.en   = sweep.active;
			gen_wr.addr = sweep.addr;
			gen_wr.data = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q    <= 1'b0;
			active_size_q <= SIZE_CAP;
			free_top_q    <= '0;
			next_fresh_q  <= '0;
			done_q        <= 1'b0;
		end else begin
			s1_valid_q <= accept;
			done_q     <= s1_valid_q;
			if (cfg_wr) begin
				active_size_q <= cfg_data;
			end
			priority if (do_clear) begin
				free_top_q   <= '0;
				next_fresh_q <= '0;
			end else if (push) begin
				free_top_q <= free_top_q + TOP_W'(1);
			end else if (pop) begin
				free_top_q <= free_top_q - TOP_W'(1);
			end else if (fresh) begin
				next_fresh_q <= next_fresh_q + SIZE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
		if (s1_valid_q) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	gha_gen_ram u_gen_ram (
		.clk     (clk),
		.wr      (gen_wr),
		.rd_en   (accept),
		.rd_addr (cmd.entry_index),
		.rd_data (gen_rdata)
	);

	gha_stack_ram u_stack_ram (
		.clk     (clk),
		.wr      (stk_wr),
		.rd_en   (accept),
		.rd_addr (free_top_q[IDX_W-1:0] - IDX_W'(1)),
		.rd_data (stk_rdata)
	);

	gha_sweep u_sweep (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (do_clear),
		.shrink   (cfg_wr),
		.new_size (cfg_eff),
		.hold     (op_gen_wr.en),
		.sweep    (sweep)
	);

endmodule

`default_nettype wire
